// ----- design/cwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types and constants for the climate window classifier.
// ----------------------------------------------------------------------------
package cwc_pkg;

    // Climate class codes as they appear on the result stream
    typedef enum logic [2:0] {
        CLS_UNKNOWN  = 3'd0,
        CLS_SUITABLE = 3'd1,
        CLS_COLD     = 3'd2,
        CLS_HOT      = 3'd3,
        CLS_DRY      = 3'd4,
        CLS_HUMID    = 3'd5,
        CLS_FAULT    = 3'd6
    } class_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TEMP_MIN        = 3'd0,
        REG_TEMP_MAX        = 3'd1,
        REG_TEMP_MARGIN     = 3'd2,
        REG_HUMID_MIN       = 3'd3,
        REG_HUMID_MAX       = 3'd4,
        REG_HUMID_MARGIN    = 3'd5,
        REG_CREDIT_INTERVAL = 3'd6
    } cfg_idx_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Reset values of the configuration registers
    localparam logic signed [14:0] TEMP_MIN_RST        = 15'sd1500;
    localparam logic signed [14:0] TEMP_MAX_RST        = 15'sd3000;
    localparam logic [10:0]        TEMP_MARGIN_RST     = 11'd50;
    localparam logic [9:0]         HUMID_MIN_RST       = 10'd400;
    localparam logic [9:0]         HUMID_MAX_RST       = 10'd800;
    localparam logic [8:0]         HUMID_MARGIN_RST    = 9'd20;
    localparam logic [31:0]        CREDIT_INTERVAL_RST = 32'd0;

    // Sensor plausibility range
    localparam logic signed [17:0] TEMP_FLOOR = -18'sd4000;
    localparam logic signed [17:0] TEMP_CEIL  = 18'sd8500;
    localparam logic [15:0]        HUMID_CEIL = 16'd1000;

    // Elapsed microseconds at which the millisecond count saturates
    localparam logic [63:0] SAT_ELAPSED = 64'd4294967296000;
    localparam logic [31:0] MS_MAX      = 32'hFFFF_FFFF;

    // Divide by 125 of a 39-bit value y = yh * 2^20 + yl:
    // 2^20 = 125 * 8388 + 76, so y / 125 = yh * 8388 + (yh * 76 + yl) / 125.
    // The small remainder term is divided by a reciprocal multiply.
    localparam logic [13:0] DIV_HI_MUL  = 14'd8388;
    localparam logic [6:0]  DIV_HI_REM  = 7'd76;
    localparam logic [26:0] DIV_RECIP   = 27'd68719477;
    localparam int          RECIP_SHIFT = 33;

    typedef struct packed {
        logic signed [14:0] temp_min;
        logic signed [14:0] temp_max;
        logic [10:0]        temp_margin;
        logic [9:0]         humid_min;
        logic [9:0]         humid_max;
        logic [8:0]         humid_margin;
        logic [31:0]        credit_interval;
    } cfg_t;

    typedef struct packed {
        logic [63:0]        now_time;
        logic               sample_ok;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
    } item_t;

    // Per-sample flags that ride alongside the millisecond computation
    typedef struct packed {
        logic   credit;
        class_t climate_class;
        logic   reading_valid;
    } tag_t;

    typedef struct packed {
        tag_t        tag;
        logic [63:0] elapsed;
    } cls_res_t;

    typedef struct packed {
        tag_t        tag;
        logic [31:0] suitable_ms;
    } out_t;

endpackage

// ----- design/cwc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module cwc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [cwc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cwc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output cwc_pkg::cfg_t                  cfg
);

    cwc_pkg::cfg_t cfg_reg;
    cwc_pkg::cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cwc_pkg::cfg_idx_t'(cfg_addr))
                cwc_pkg::REG_TEMP_MIN:        cfg_next.temp_min        = cfg_wdata[14:0];
                cwc_pkg::REG_TEMP_MAX:        cfg_next.temp_max        = cfg_wdata[14:0];
                cwc_pkg::REG_TEMP_MARGIN:     cfg_next.temp_margin     = cfg_wdata[10:0];
                cwc_pkg::REG_HUMID_MIN:       cfg_next.humid_min       = cfg_wdata[9:0];
                cwc_pkg::REG_HUMID_MAX:       cfg_next.humid_max       = cfg_wdata[9:0];
                cwc_pkg::REG_HUMID_MARGIN:    cfg_next.humid_margin    = cfg_wdata[8:0];
                cwc_pkg::REG_CREDIT_INTERVAL: cfg_next.credit_interval = cfg_wdata[31:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_min        <= cwc_pkg::TEMP_MIN_RST;
            cfg_reg.temp_max        <= cwc_pkg::TEMP_MAX_RST;
            cfg_reg.temp_margin     <= cwc_pkg::TEMP_MARGIN_RST;
            cfg_reg.humid_min       <= cwc_pkg::HUMID_MIN_RST;
            cfg_reg.humid_max       <= cwc_pkg::HUMID_MAX_RST;
            cfg_reg.humid_margin    <= cwc_pkg::HUMID_MARGIN_RST;
            cfg_reg.credit_interval <= cwc_pkg::CREDIT_INTERVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/cwc_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_classify
// Window comparator with hysteresis, suitable-state timing and credits.
// Holds the class state and updates it once per loaded sample.
// ----------------------------------------------------------------------------
module cwc_classify (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cwc_pkg::cfg_t     cfg,
    input  cwc_pkg::item_t    item,
    output cwc_pkg::cls_res_t res
);

    cwc_pkg::class_t   class_reg;
    cwc_pkg::class_t   class_next;
    logic [63:0]       start_reg;
    logic [63:0]       start_next;
    logic [63:0]       last_reg;
    logic [63:0]       last_next;
    cwc_pkg::cls_res_t res_reg;
    cwc_pkg::cls_res_t res_next;

    logic               in_suitable;
    logic signed [17:0] t_val;
    logic signed [17:0] h_val;
    logic signed [17:0] t_min;
    logic signed [17:0] t_max;
    logic signed [17:0] t_mrg;
    logic signed [17:0] h_min;
    logic signed [17:0] h_max;
    logic signed [17:0] h_mrg;
    logic signed [17:0] t_lo;
    logic signed [17:0] t_hi;
    logic signed [17:0] h_lo;
    logic signed [17:0] h_hi;
    logic               reading_ok;
    cwc_pkg::class_t    judged;
    logic [63:0]        since_start;
    logic [63:0]        since_credit;
    logic               credit_due;

    assign in_suitable = (class_reg == cwc_pkg::CLS_SUITABLE);

    // Operands extended to a common signed width
    assign t_val = {{2{item.temperature[15]}}, item.temperature};
    assign h_val = {2'b00, item.humidity};
    assign t_min = {{3{cfg.temp_min[14]}}, cfg.temp_min};
    assign t_max = {{3{cfg.temp_max[14]}}, cfg.temp_max};
    assign t_mrg = {7'd0, cfg.temp_margin};
    assign h_min = {8'd0, cfg.humid_min};
    assign h_max = {8'd0, cfg.humid_max};
    assign h_mrg = {9'd0, cfg.humid_margin};

    // Limits widen while suitable, narrow otherwise
    assign t_lo = in_suitable ? (t_min - t_mrg) : (t_min + t_mrg);
    assign t_hi = in_suitable ? (t_max + t_mrg) : (t_max - t_mrg);
    assign h_lo = in_suitable ? (h_min - h_mrg) : (h_min + h_mrg);
    assign h_hi = in_suitable ? (h_max + h_mrg) : (h_max - h_mrg);

    // Sensor plausibility
    assign reading_ok = item.sample_ok
                        && (t_val >= cwc_pkg::TEMP_FLOOR)
                        && (t_val <= cwc_pkg::TEMP_CEIL)
                        && (item.humidity <= cwc_pkg::HUMID_CEIL);

    // Classification in priority order
    always_comb
    begin
        if (!reading_ok)
            judged = cwc_pkg::CLS_FAULT;
        else if (t_val < t_lo)
            judged = cwc_pkg::CLS_COLD;
        else if (t_val > t_hi)
            judged = cwc_pkg::CLS_HOT;
        else if (h_val < h_lo)
            judged = cwc_pkg::CLS_DRY;
        else if (h_val > h_hi)
            judged = cwc_pkg::CLS_HUMID;
        else
            judged = cwc_pkg::CLS_SUITABLE;
    end

    // Elapsed times, modulo 2^64
    assign since_start  = item.now_time - start_reg;
    assign since_credit = item.now_time - last_reg;
    assign credit_due   = (cfg.credit_interval != 32'd0)
                          && (since_credit >= {32'd0, cfg.credit_interval});

    // Next state and result
    always_comb
    begin
        class_next                 = judged;
        start_next                 = 64'd0;
        last_next                  = 64'd0;
        res_next.tag.credit        = 1'b0;
        res_next.tag.climate_class = judged;
        res_next.tag.reading_valid = reading_ok;
        res_next.elapsed           = 64'd0;
        if (judged == cwc_pkg::CLS_SUITABLE)
        begin
            if (!in_suitable)
            begin
                // On entering suitable, elapsed is zero and there is no credit
                start_next = item.now_time;
                last_next  = item.now_time;
            end
            else
            begin
                start_next       = start_reg;
                res_next.elapsed = since_start;
                if (credit_due)
                begin
                    last_next           = item.now_time;
                    res_next.tag.credit = 1'b1;
                end
                else
                begin
                    last_next = last_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= cwc_pkg::CLS_UNKNOWN;
            start_reg <= 64'd0;
            last_reg  <= 64'd0;
        end
        else if (load)
        begin
            class_reg <= class_next;
            start_reg <= start_next;
            last_reg  <= last_next;
        end
    end

    // Result register, payload only
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- design/cwc_ms_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_ms_div
// Microseconds to milliseconds, saturating to 32 bits. Three registered
// steps: split and constant multiplies, reciprocal multiply, final sum.
// ----------------------------------------------------------------------------
module cwc_ms_div (
    input  logic              clk,
    input  logic              load_split,
    input  logic              load_recip,
    input  logic              load_out,
    input  cwc_pkg::cls_res_t res,
    output cwc_pkg::out_t     result
);

    // Split step
    logic [38:0] y;
    logic [18:0] y_hi;
    logic [19:0] y_lo;
    logic        sat_next;
    logic [32:0] base_next;
    logic [25:0] rem_next;

    cwc_pkg::tag_t s1_tag_reg;
    logic          s1_sat_reg;
    logic [32:0]   s1_base_reg;
    logic [25:0]   s1_rem_reg;

    // Reciprocal step
    logic [52:0] prod;
    logic [19:0] qlo_next;

    cwc_pkg::tag_t s2_tag_reg;
    logic          s2_sat_reg;
    logic [32:0]   s2_base_reg;
    logic [19:0]   s2_qlo_reg;

    // Output step
    logic [32:0]   q_sum;
    cwc_pkg::out_t out_next;
    cwc_pkg::out_t out_reg;

    // elapsed / 1000 = (elapsed >> 3) / 125, valid below the saturation point
    assign sat_next  = (res.elapsed >= cwc_pkg::SAT_ELAPSED);
    assign y         = res.elapsed[41:3];
    assign y_hi      = y[38:20];
    assign y_lo      = y[19:0];
    assign base_next = {14'd0, y_hi} * {19'd0, cwc_pkg::DIV_HI_MUL};
    assign rem_next  = 26'({7'd0, y_hi} * {19'd0, cwc_pkg::DIV_HI_REM}) + {6'd0, y_lo};

    always_ff @(posedge clk)
    begin
        if (load_split)
        begin
            s1_tag_reg  <= res.tag;
            s1_sat_reg  <= sat_next;
            s1_base_reg <= base_next;
            s1_rem_reg  <= rem_next;
        end
    end

    // rem / 125 by reciprocal multiply, exact for rem below 2^26
    assign prod     = {27'd0, s1_rem_reg} * {26'd0, cwc_pkg::DIV_RECIP};
    assign qlo_next = prod[52:cwc_pkg::RECIP_SHIFT];

    always_ff @(posedge clk)
    begin
        if (load_recip)
        begin
            s2_tag_reg  <= s1_tag_reg;
            s2_sat_reg  <= s1_sat_reg;
            s2_base_reg <= s1_base_reg;
            s2_qlo_reg  <= qlo_next;
        end
    end

    // Final sum and saturation
    assign q_sum                = s2_base_reg + {13'd0, s2_qlo_reg};
    assign out_next.tag         = s2_tag_reg;
    assign out_next.suitable_ms = s2_sat_reg ? cwc_pkg::MS_MAX : q_sum[31:0];

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= out_next;
    end

    assign result = out_reg;

endmodule

// ----- design/climate_window_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// climate_window_classifier
// Temperature/humidity window comparator with hysteresis, suitable-time
// tracking in milliseconds and periodic credit pulses.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake              Payload
//  s_axis   in   s_axis_tvalid/tready   tdata: now_time, temperature, humidity
//                                       tuser: sample_ok
//  m_axis   out  m_axis_tvalid/tready   tdata: suitable_ms
//                                       tuser: credit, climate_class,
//                                              reading_valid
//  cfg      in   cfg_wr_en              cfg_addr, cfg_wdata
//
//  One sample per cycle sustained while m_axis_tready allows. Five registers
//  lie in line (input register, classifier, two divide steps, output) between
//  the edge that takes a sample and the offer of its result.
//  The classifier state updates as each sample is loaded, which is what
//  lets samples follow back to back.
//  Each stage advances whenever its successor can take data, so bubbles
//  collapse and input is taken while a finished result waits.
//  Reset empties the pipeline, returns the class to unknown and loads the
//  default configuration.
// ----------------------------------------------------------------------------
module climate_window_classifier (
    input  logic                           clk,
    input  logic                           rst_n,
    // fields: now_time[63:0], temperature[79:64], humidity[95:80]
    input  logic [95:0]                    s_axis_tdata,
    // fields: sample_ok[0]
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // fields: suitable_ms[31:0]
    output logic [31:0]                    m_axis_tdata,
    // fields: credit[0], climate_class[3:1], reading_valid[4]
    output logic [4:0]                     m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           cfg_wr_en,
    input  logic [cwc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cwc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    cwc_pkg::cfg_t     cfg;
    cwc_pkg::item_t    item_reg;
    cwc_pkg::cls_res_t cls_res;
    cwc_pkg::out_t     result;

    logic in_vld_reg;
    logic cls_vld_reg;
    logic s1_vld_reg;
    logic s2_vld_reg;
    logic out_vld_reg;

    logic in_rdy;
    logic cls_rdy;
    logic s1_rdy;
    logic s2_rdy;
    logic out_rdy;

    // Stage readiness, back from the output
    assign out_rdy = !out_vld_reg || m_axis_tready;
    assign s2_rdy  = !s2_vld_reg  || out_rdy;
    assign s1_rdy  = !s1_vld_reg  || s2_rdy;
    assign cls_rdy = !cls_vld_reg || s1_rdy;
    assign in_rdy  = !in_vld_reg  || cls_rdy;

    assign s_axis_tready = in_rdy;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            cls_vld_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_rdy)
                in_vld_reg <= s_axis_tvalid;
            if (cls_rdy)
                cls_vld_reg <= in_vld_reg;
            if (s1_rdy)
                s1_vld_reg <= cls_vld_reg;
            if (s2_rdy)
                s2_vld_reg <= s1_vld_reg;
            if (out_rdy)
                out_vld_reg <= s2_vld_reg;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && in_rdy)
        begin
            item_reg.now_time    <= s_axis_tdata[63:0];
            item_reg.temperature <= s_axis_tdata[79:64];
            item_reg.humidity    <= s_axis_tdata[95:80];
            item_reg.sample_ok   <= s_axis_tuser;
        end
    end

    cwc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cwc_classify u_classify (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (in_vld_reg && cls_rdy),
        .cfg   (cfg),
        .item  (item_reg),
        .res   (cls_res)
    );

    cwc_ms_div u_ms_div (
        .clk        (clk),
        .load_split (cls_vld_reg && s1_rdy),
        .load_recip (s1_vld_reg && s2_rdy),
        .load_out   (s2_vld_reg && out_rdy),
        .res        (cls_res),
        .result     (result)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = result.suitable_ms;
    assign m_axis_tuser  = {result.tag.reading_valid, result.tag.climate_class,
                            result.tag.credit};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An empty output register means the whole pipeline can take a sample
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // Outside the suitable class there is neither elapsed time nor credit
    a_unsuitable_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && result.tag.climate_class != cwc_pkg::CLS_SUITABLE)
        |-> (result.suitable_ms == 32'd0 && !result.tag.credit))
        else $error("time or credit reported outside the suitable class");

    // A rejected reading is always reported as a sensor fault
    a_fault_class: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !result.tag.reading_valid)
        |-> (result.tag.climate_class == cwc_pkg::CLS_FAULT))
        else $error("invalid reading not classed as fault");

    // Every delivered result carries a decided class
    a_class_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (result.tag.climate_class != cwc_pkg::CLS_UNKNOWN))
        else $error("result delivered with unknown class");

endmodule

// ----- tb/sv/climate_window_classifier_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// climate_window_classifier_test
// Self-checking bench for the climate window classifier: a directed sweep of
// range edges, hysteresis edges and time wrap, then randomized sensor traffic
// under several register settings, checked against a behavioral model or pinned results.
// ----------------------------------------------------------------------------
module climate_window_classifier_test;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int SAMPLES_PER_SET  = 104;
    localparam int PRINT_CAP        = 50;

    // Sensor plausibility range
    localparam int SENSOR_T_LO = -4000;
    localparam int SENSOR_T_HI = 8500;
    localparam int SENSOR_H_HI = 1000;

    // Register settings used by the random phases
    typedef enum int {
        SET_RANDOM,
        SET_WIDEST,
        SET_INVERTED,
        SET_POINT,
        SET_RAW,
        SET_DEFAULT
    } setting_t;

    // Directed stimulus row; res is only meaningful where pin is set
    typedef struct {
        logic [63:0]   now;
        bit            ok;
        int            temp;
        int            hum;
        bit            pin;
        cwc_pkg::out_t res;
    } probe_t;

    logic        clk;
    logic        rst_n;
    logic [95:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        cfg_wr_en;
    logic [cwc_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [cwc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // Pinned expectation that travels with the current sample
    logic          pin_valid;
    cwc_pkg::out_t pin_result;

    // Register mirror
    int          cfg_temp_min;
    int          cfg_temp_max;
    int          cfg_temp_margin;
    int          cfg_humid_min;
    int          cfg_humid_max;
    int          cfg_humid_margin;
    logic [31:0] cfg_interval;

    // Model state
    cwc_pkg::class_t class_q;
    logic [63:0]     suitable_since;
    logic [63:0]     last_credit_at;

    cwc_pkg::out_t expected_q[$];
    probe_t        probes[$];
    logic [63:0]   clock_us;
    bit            send_eager;
    bit            take_eager;

    int mismatches;
    int samples_sent;
    int results_checked;
    int settings_applied;
    int credits_seen;
    int suitable_seen;
    int faults_seen;
    int saturated_seen;
    int quiet_cycles;

    climate_window_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral model of one sample
    // ------------------------------------------------------------------------
    function automatic cwc_pkg::out_t classify_sample(cwc_pkg::item_t s);
        cwc_pkg::out_t   r;
        int              t;
        int              h;
        int              tm;
        int              hm;
        logic            valid;
        cwc_pkg::class_t nxt;
        logic [63:0]     span;
        r = '0;
        t = int'(s.temperature);
        h = int'(s.humidity);
        valid = s.sample_ok && t >= SENSOR_T_LO && t <= SENSOR_T_HI && h <= SENSOR_H_HI;
        // hysteresis: widen while suitable, narrow otherwise
        tm = (class_q == cwc_pkg::CLS_SUITABLE) ? cfg_temp_margin : -cfg_temp_margin;
        hm = (class_q == cwc_pkg::CLS_SUITABLE) ? cfg_humid_margin : -cfg_humid_margin;
        if (!valid)
            nxt = cwc_pkg::CLS_FAULT;
        else if (t < cfg_temp_min - tm)
            nxt = cwc_pkg::CLS_COLD;
        else if (t > cfg_temp_max + tm)
            nxt = cwc_pkg::CLS_HOT;
        else if (h < cfg_humid_min - hm)
            nxt = cwc_pkg::CLS_DRY;
        else if (h > cfg_humid_max + hm)
            nxt = cwc_pkg::CLS_HUMID;
        else
            nxt = cwc_pkg::CLS_SUITABLE;

        if (nxt != cwc_pkg::CLS_SUITABLE)
        begin
            class_q        = nxt;
            suitable_since = '0;
            last_credit_at = '0;
        end
        else
        begin
            if (class_q != cwc_pkg::CLS_SUITABLE)
            begin
                suitable_since = s.now_time;
                last_credit_at = s.now_time;
            end
            class_q = cwc_pkg::CLS_SUITABLE;
            // elapsed time wraps modulo 2^64
            span = (s.now_time - suitable_since) / 64'd1000;
            r.suitable_ms = (span > 64'hFFFF_FFFF) ? cwc_pkg::MS_MAX : span[31:0];
            if (cfg_interval != 32'd0
                && (s.now_time - last_credit_at) >= {32'd0, cfg_interval})
            begin
                last_credit_at = s.now_time;
                r.tag.credit   = 1'b1;
            end
        end
        r.tag.climate_class = class_q;
        r.tag.reading_valid = valid;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                     results_checked, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: check results, track register writes, predict samples
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        cwc_pkg::out_t  want;
        cwc_pkg::item_t smp;
        // result transaction
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result, suitable_ms", 64'(m_axis_tdata), 64'd0);
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tuser[0] !== want.tag.credit)
                    report_mismatch("credit", 64'(m_axis_tuser[0]), 64'(want.tag.credit));
                if (m_axis_tuser[3:1] !== want.tag.climate_class)
                    report_mismatch("climate_class", 64'(m_axis_tuser[3:1]),
                                    64'(want.tag.climate_class));
                if (m_axis_tuser[4] !== want.tag.reading_valid)
                    report_mismatch("reading_valid", 64'(m_axis_tuser[4]),
                                    64'(want.tag.reading_valid));
                if (m_axis_tdata !== want.suitable_ms)
                    report_mismatch("suitable_ms", 64'(m_axis_tdata),
                                    64'(want.suitable_ms));
                results_checked++;
                if (want.tag.credit)
                    credits_seen++;
                if (want.tag.climate_class == cwc_pkg::CLS_SUITABLE)
                    suitable_seen++;
                if (want.tag.climate_class == cwc_pkg::CLS_FAULT)
                    faults_seen++;
                if (want.suitable_ms == cwc_pkg::MS_MAX)
                    saturated_seen++;
            end
        end

        // sample transaction
        if (s_axis_tvalid && s_axis_tready)
        begin
            smp.now_time    = s_axis_tdata[63:0];
            smp.temperature = s_axis_tdata[79:64];
            smp.humidity    = s_axis_tdata[95:80];
            smp.sample_ok   = s_axis_tuser;
            want = classify_sample(smp);
            expected_q.push_back(pin_valid ? pin_result : want);
        end

        // register mirror
        if (cfg_wr_en)
        begin
            case (cwc_pkg::cfg_idx_t'(cfg_addr))
                cwc_pkg::REG_TEMP_MIN:
                    cfg_temp_min     = int'($signed(cfg_wdata[14:0]));
                cwc_pkg::REG_TEMP_MAX:
                    cfg_temp_max     = int'($signed(cfg_wdata[14:0]));
                cwc_pkg::REG_TEMP_MARGIN:
                    cfg_temp_margin  = int'(cfg_wdata[10:0]);
                cwc_pkg::REG_HUMID_MIN:
                    cfg_humid_min    = int'(cfg_wdata[9:0]);
                cwc_pkg::REG_HUMID_MAX:
                    cfg_humid_max    = int'(cfg_wdata[9:0]);
                cwc_pkg::REG_HUMID_MARGIN:
                    cfg_humid_margin = int'(cfg_wdata[8:0]);
                cwc_pkg::REG_CREDIT_INTERVAL:
                    cfg_interval     = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Watchdog: no transaction of any kind for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink with random stalls
    // ------------------------------------------------------------------------
    initial
    begin : sink
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_eager = !take_eager;
            stall = take_eager ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic probe_t row(logic [63:0] now, bit ok, int t, int h, bit pin,
                                   cwc_pkg::class_t cls, bit valid, logic [31:0] ms);
        probe_t p;
        p.now                   = now;
        p.ok                    = ok;
        p.temp                  = t;
        p.hum                   = h;
        p.pin                   = pin;
        p.res                   = '0;
        p.res.tag.climate_class = cls;
        p.res.tag.reading_valid = valid;
        p.res.suitable_ms       = ms;
        return p;
    endfunction

    // One sample transaction, preceded by a random gap
    task automatic send_sample(cwc_pkg::item_t s, logic pin, cwc_pkg::out_t pinned);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_eager = !send_eager;
        gap = send_eager ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.humidity, s.temperature, s.now_time};
        s_axis_tuser  <= s.sample_ok;
        pin_valid     <= pin;
        pin_result    <= pinned;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
    endtask

    // Stop sending and let every outstanding result come back; the first
    // edge lets the scoreboard log the last sample before the queue is read
    task automatic settle;
        s_axis_tvalid <= 1'b0;
        pin_valid     <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cwc_pkg::cfg_idx_t idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic apply_setting(setting_t kind);
        int          tmin;
        int          tmax;
        int          tmarg;
        int          hmin;
        int          hmax;
        int          hmarg;
        logic [31:0] ival;
        case (kind)
            SET_WIDEST:
            begin
                tmin = SENSOR_T_LO; tmax = SENSOR_T_HI; tmarg = 2000;
                hmin = 0; hmax = 1000; hmarg = 500; ival = 32'd1;
            end
            SET_INVERTED:
            begin
                tmin = SENSOR_T_HI; tmax = SENSOR_T_LO; tmarg = 0;
                hmin = 1000; hmax = 0; hmarg = 0; ival = 32'd500;
            end
            SET_POINT:
            begin
                tmin = pick(SENSOR_T_LO, SENSOR_T_HI); tmax = tmin; tmarg = pick(0, 3);
                hmin = pick(0, 1000); hmax = hmin; hmarg = pick(0, 3);
                ival = 32'hFFFF_FFFF;
            end
            SET_RAW:
            begin
                tmin = $urandom; tmax = $urandom; tmarg = $urandom;
                hmin = $urandom; hmax = $urandom; hmarg = $urandom; ival = $urandom;
            end
            SET_DEFAULT:
            begin
                tmin  = int'(cwc_pkg::TEMP_MIN_RST);
                tmax  = int'(cwc_pkg::TEMP_MAX_RST);
                tmarg = int'(cwc_pkg::TEMP_MARGIN_RST);
                hmin  = int'(cwc_pkg::HUMID_MIN_RST);
                hmax  = int'(cwc_pkg::HUMID_MAX_RST);
                hmarg = int'(cwc_pkg::HUMID_MARGIN_RST);
                ival  = 32'd1000;
            end
            default:
            begin
                tmin  = pick(SENSOR_T_LO, SENSOR_T_HI);
                tmax  = pick(tmin, SENSOR_T_HI);
                tmarg = pick(0, 2000);
                hmin  = pick(0, 1000);
                hmax  = pick(hmin, 1000);
                hmarg = pick(0, 500);
                ival  = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'(pick(1, 20000));
            end
        endcase
        write_reg(cwc_pkg::REG_TEMP_MIN, tmin);
        write_reg(cwc_pkg::REG_TEMP_MAX, tmax);
        write_reg(cwc_pkg::REG_TEMP_MARGIN, tmarg);
        write_reg(cwc_pkg::REG_HUMID_MIN, hmin);
        write_reg(cwc_pkg::REG_HUMID_MAX, hmax);
        write_reg(cwc_pkg::REG_HUMID_MARGIN, hmarg);
        write_reg(cwc_pkg::REG_CREDIT_INTERVAL, ival);
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // Random sample: mostly around the window, some near the sensor range
    // edges, some raw; time mostly moves forward in small steps
    function automatic cwc_pkg::item_t make_sample();
        cwc_pkg::item_t s;
        int             lo;
        int             hi;
        int             tmp;
        int             r;
        r = $urandom_range(0, 199);
        if (r < 2)
            clock_us = {$urandom, $urandom};
        else if (r < 8)
            clock_us = clock_us + 64'($urandom);
        else
            clock_us = clock_us + 64'($urandom_range(0, 4000));
        s.now_time  = clock_us;
        s.sample_ok = ($urandom_range(0, 15) != 0);

        lo = cfg_temp_min - cfg_temp_margin - 30;
        hi = cfg_temp_max + cfg_temp_margin + 30;
        if (hi < lo)
        begin
            tmp = lo; lo = hi; hi = tmp;
        end
        r = $urandom_range(0, 99);
        if (r < 75)
            s.temperature = 16'(pick(lo, hi));
        else if (r < 88)
            s.temperature = $urandom_range(0, 1) ? 16'(pick(-4003, -3997))
                                                 : 16'(pick(8497, 8503));
        else
            s.temperature = 16'($urandom);

        lo = cfg_humid_min - cfg_humid_margin - 30;
        hi = cfg_humid_max + cfg_humid_margin + 30;
        if (hi < lo)
        begin
            tmp = lo; lo = hi; hi = tmp;
        end
        if (lo < 0)
            lo = 0;
        r = $urandom_range(0, 99);
        if (r < 75)
            s.humidity = 16'(pick(lo, hi));
        else if (r < 88)
            s.humidity = 16'(pick(997, 1003));
        else
            s.humidity = 16'($urandom);
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        cwc_pkg::item_t s;
        setting_t       plan[8];
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        pin_valid     <= 1'b0;
        pin_result    <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= cwc_pkg::REG_TEMP_MIN;
        cfg_wdata     <= '0;
        class_q        = cwc_pkg::CLS_UNKNOWN;
        suitable_since = '0;
        last_credit_at = '0;
        cfg_temp_min     = int'(cwc_pkg::TEMP_MIN_RST);
        cfg_temp_max     = int'(cwc_pkg::TEMP_MAX_RST);
        cfg_temp_margin  = int'(cwc_pkg::TEMP_MARGIN_RST);
        cfg_humid_min    = int'(cwc_pkg::HUMID_MIN_RST);
        cfg_humid_max    = int'(cwc_pkg::HUMID_MAX_RST);
        cfg_humid_margin = int'(cwc_pkg::HUMID_MARGIN_RST);
        cfg_interval     = cwc_pkg::CREDIT_INTERVAL_RST;

        // Directed rows at reset settings (temp 15.00..30.00, RH 40.0..80.0)
        probes.push_back(row(0,    0, 2000,   600,   1, cwc_pkg::CLS_FAULT, 0, 0));
        probes.push_back(row(10,   1, -4001,  600,   1, cwc_pkg::CLS_FAULT, 0, 0));
        probes.push_back(row(20,   1, 8501,   600,   1, cwc_pkg::CLS_FAULT, 0, 0));
        probes.push_back(row(30,   1, -32768, 600,   1, cwc_pkg::CLS_FAULT, 0, 0));
        probes.push_back(row(40,   1, 32767,  600,   1, cwc_pkg::CLS_FAULT, 0, 0));
        probes.push_back(row(50,   1, 2000,   1001,  1, cwc_pkg::CLS_FAULT, 0, 0));
        probes.push_back(row(60,   1, 2000,   65535, 1, cwc_pkg::CLS_FAULT, 0, 0));
        probes.push_back(row(70,   1, -4000,  600,   1, cwc_pkg::CLS_COLD,  1, 0));
        probes.push_back(row(80,   1, 8500,   600,   1, cwc_pkg::CLS_HOT,   1, 0));
        probes.push_back(row(90,   1, 2000,   0,     1, cwc_pkg::CLS_DRY,   1, 0));
        probes.push_back(row(100,  1, 2000,   1000,  1, cwc_pkg::CLS_HUMID, 1, 0));
        // narrowed edges while not suitable
        probes.push_back(row(110,  1, 1549,   600,   1, cwc_pkg::CLS_COLD,  1, 0));
        probes.push_back(row(120,  1, 2951,   600,   1, cwc_pkg::CLS_HOT,   1, 0));
        probes.push_back(row(130,  1, 2000,   419,   1, cwc_pkg::CLS_DRY,   1, 0));
        probes.push_back(row(140,  1, 2000,   781,   1, cwc_pkg::CLS_HUMID, 1, 0));
        // enter suitable on the narrow corner, then hold on the wide corner
        probes.push_back(row(1000, 1, 1550,   420,   1, cwc_pkg::CLS_SUITABLE, 1, 0));
        probes.push_back(row(3500, 1, 1451,   819,   0, cwc_pkg::CLS_UNKNOWN, 0, 0));
        probes.push_back(row(4000, 1, 2000,   600,   0, cwc_pkg::CLS_UNKNOWN, 0, 0));
        probes.push_back(row(5000, 1, 3051,   600,   1, cwc_pkg::CLS_HOT,   1, 0));
        // time running backwards saturates the suitable time
        probes.push_back(row(64'h8000_0000_0000_0000, 1, 2950, 780, 1,
                             cwc_pkg::CLS_SUITABLE, 1, 0));
        probes.push_back(row(64'h8000_0000_0000_03E8, 1, 2000, 600, 0,
                             cwc_pkg::CLS_UNKNOWN, 0, 0));
        probes.push_back(row(5, 1, 2000, 600, 1, cwc_pkg::CLS_SUITABLE, 1, cwc_pkg::MS_MAX));
        probes.push_back(row(6, 0, 2000, 600, 1, cwc_pkg::CLS_FAULT, 0, 0));
        // time wraps forward through zero
        probes.push_back(row(64'hFFFF_FFFF_FFFF_FFFF, 1, 2000, 600, 1,
                             cwc_pkg::CLS_SUITABLE, 1, 0));
        probes.push_back(row(0, 1, 2000, 600, 0, cwc_pkg::CLS_UNKNOWN, 0, 0));
        probes.push_back(row(999_999, 1, 2000, 600, 0, cwc_pkg::CLS_UNKNOWN, 0, 0));

        plan = '{SET_RANDOM, SET_WIDEST, SET_POINT, SET_INVERTED,
                 SET_RANDOM, SET_RAW, SET_DEFAULT, SET_RANDOM};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (probes[i])
        begin
            s.now_time    = probes[i].now;
            s.sample_ok   = probes[i].ok;
            s.temperature = 16'(probes[i].temp);
            s.humidity    = 16'(probes[i].hum);
            send_sample(s, probes[i].pin, probes[i].res);
        end
        settle();

        // random part, one register setting per phase
        foreach (plan[p])
        begin
            apply_setting(plan[p]);
            clock_us = {$urandom, $urandom};
            repeat (SAMPLES_PER_SET)
            begin
                s = make_sample();
                send_sample(s, 1'b0, '0);
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("results never delivered", 64'(expected_q.size()), 64'd0);

        $display("Sent %0d samples over %0d register settings, checked %0d results",
                 samples_sent, settings_applied + 1, results_checked);
        $display("Seen: %0d suitable, %0d sensor faults, %0d credits, %0d saturated times",
                 suitable_seen, faults_seen, credits_seen, saturated_seen);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
